// ===== rtl/bmma_pkg.sv =====
package bmma_pkg;

  localparam int MAX_ORDER = 8;
  localparam int IDX_W     = $clog2(MAX_ORDER);
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
  localparam int ORD_W     = 4;
  localparam int AB_W      = 16;
  localparam int PROD_W    = 2 * AB_W;
  localparam int C_W       = 48;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_ACC   = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  localparam logic signed [C_W-1:0] C_MAX = {1'b0, {(C_W-1){1'b1}}};
  localparam logic signed [C_W-1:0] C_MIN = {1'b1, {(C_W-1){1'b0}}};

  typedef struct packed {
    logic             ab_wr;     // write A and B entry at the request index
    logic             c_clr;     // drop every C entry and flag
    logic             c_rd_req;  // read C at the request index
    logic             c_rd_acc;  // read C at (i, j)
    logic             ab_rd;     // issue A(i, k) and B(k, j) reads
    logic             acc_load;  // load accumulator from C read data
    logic             c_wr;      // write accumulator back to C(i, j)
    logic             out_load;  // move C read data to the output register
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;  // products still in flight
    logic out_free;   // output register can take a result
  } dp_status_t;

  // Last valid index for the configured order: zero acts as one, too large
  // clamps to MAX_ORDER.
  function automatic logic [IDX_W-1:0] act_last(input logic [ORD_W-1:0] ord);
    logic [ORD_W-1:0] n;
    if (ord == '0) begin
      n = ORD_W'(1);
    end else if (ord > ORD_W'(MAX_ORDER)) begin
      n = ORD_W'(MAX_ORDER);
    end else begin
      n = ord;
    end
    return IDX_W'(n - ORD_W'(1));
  endfunction

endpackage

// ===== rtl/bmma_dp.sv =====
module bmma_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bmma_pkg::dp_cmd_t                   cmd,
  output bmma_pkg::dp_status_t                status,
  input  logic [bmma_pkg::IDX_W-1:0]          last,
  input  logic [bmma_pkg::IDX_W-1:0]          in_row,
  input  logic [bmma_pkg::IDX_W-1:0]          in_col,
  input  logic signed [bmma_pkg::AB_W-1:0]    in_a,
  input  logic signed [bmma_pkg::AB_W-1:0]    in_b,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [bmma_pkg::C_W-1:0]     out_c_value,
  output logic                                out_saturated
);
  import bmma_pkg::*;

  logic signed [AB_W-1:0] a_mem [DEPTH];
  logic signed [AB_W-1:0] b_mem [DEPTH];
  logic [C_W:0]           c_mem [DEPTH];   // {sticky flag, value}
  logic [DEPTH-1:0]       c_valid_r;

  logic signed [AB_W-1:0]   a_q_r, b_q_r;
  logic [C_W:0]             c_q_r;
  logic                     c_vq_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     v1_r, v2_r;
  logic signed [C_W-1:0]    acc_r, acc_nxt;
  logic                     acc_sat_r, acc_sat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [C_W-1:0]    out_c_r;
  logic                     out_sat_r;

  logic [ADDR_W-1:0]  req_addr, acc_addr, a_rd_addr, b_rd_addr, c_rd_addr;
  logic               in_order;
  logic signed [C_W:0] sum;

  assign req_addr  = {in_row, in_col};
  assign acc_addr  = {cmd.i, cmd.j};
  assign a_rd_addr = {cmd.i, cmd.k};
  assign b_rd_addr = {cmd.k, cmd.j};
  assign c_rd_addr = cmd.c_rd_req ? req_addr : acc_addr;
  assign in_order  = (in_row <= last) && (in_col <= last);

  // A and B stores
  always_ff @(posedge clk) begin
    if (cmd.ab_wr && in_order) begin
      a_mem[req_addr] <= in_a;
      b_mem[req_addr] <= in_b;
    end
    if (cmd.ab_rd) begin
      a_q_r <= a_mem[a_rd_addr];
      b_q_r <= b_mem[b_rd_addr];
    end
  end

  // C store; the valid bits make never-written entries read as zero
  always_ff @(posedge clk) begin
    if (cmd.c_wr) begin
      c_mem[acc_addr] <= {acc_sat_r, acc_r};
    end
    if (cmd.c_rd_req || cmd.c_rd_acc) begin
      c_q_r <= c_mem[c_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.c_clr) begin
      c_valid_r <= '0;
    end else if (cmd.c_wr) begin
      c_valid_r[acc_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.c_rd_req) begin
      c_vq_r <= c_valid_r[c_rd_addr] & in_order;
    end else if (cmd.c_rd_acc) begin
      c_vq_r <= c_valid_r[c_rd_addr];
    end
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (v1_r) begin
      prod_r <= PROD_W'(a_q_r) * PROD_W'(b_q_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.ab_rd;
      v2_r <= v1_r;
    end
  end

  // Saturating accumulate
  assign sum = {acc_r[C_W-1], acc_r} + (C_W+1)'(prod_r);

  always_comb begin
    acc_nxt     = acc_r;
    acc_sat_nxt = acc_sat_r;
    if (cmd.acc_load) begin
      acc_nxt     = c_vq_r ? $signed(c_q_r[C_W-1:0]) : '0;
      acc_sat_nxt = c_vq_r & c_q_r[C_W];
    end else if (v2_r) begin
      if (sum[C_W] != sum[C_W-1]) begin
        acc_nxt     = sum[C_W] ? C_MIN : C_MAX;
        acc_sat_nxt = 1'b1;
      end else begin
        acc_nxt = sum[C_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    acc_sat_r <= acc_sat_nxt;
  end

  // Output register
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_c_r   <= c_vq_r ? $signed(c_q_r[C_W-1:0]) : '0;
      out_sat_r <= c_vq_r & c_q_r[C_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_c_value      = out_c_r;
  assign out_saturated    = out_sat_r;
  assign status.pipe_busy = v1_r | v2_r;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

// ===== rtl/bmma_ctrl.sv =====
module bmma_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_req_type,
  input  logic [bmma_pkg::IDX_W-1:0]  last,
  input  bmma_pkg::dp_status_t        status,
  output bmma_pkg::dp_cmd_t           cmd
);
  import bmma_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_RD_OUT = 3'd1;
  localparam logic [2:0] ST_C_RD   = 3'd2;
  localparam logic [2:0] ST_K_RUN  = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.k     = k_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_LOAD:  cmd.ab_wr = 1'b1;
            REQ_CLEAR: cmd.c_clr = 1'b1;
            REQ_ACC: begin
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = ST_C_RD;
            end
            REQ_READ: begin
              cmd.c_rd_req = 1'b1;
              state_nxt    = ST_RD_OUT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_C_RD: begin
        cmd.c_rd_acc = 1'b1;
        k_nxt        = '0;
        state_nxt    = ST_K_RUN;
      end
      ST_K_RUN: begin
        cmd.ab_rd    = 1'b1;
        cmd.acc_load = (k_r == '0);
        if (k_r == last) begin
          state_nxt = ST_DRAIN;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.c_wr = 1'b1;
          if (j_r == last) begin
            j_nxt = '0;
            if (i_r == last) begin
              state_nxt = ST_IDLE;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = ST_C_RD;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = ST_C_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

endmodule

// ===== rtl/block_matrix_multiply_accumulate.sv =====
// Block matrix multiply-accumulate on square blocks of up to 8 x 8 entries.
// Input channel (in_valid/in_ready) carries one request per transfer:
//   load one A and one B entry (Q8.8), clear C, accumulate C += A * B over
//   the active order, or read one C entry (Q32.16 in 48 bits, saturating).
// Result channel (out_valid/out_ready) carries one transfer per read request:
//   the C value and its sticky saturation flag. Other requests give none.
// Configuration: APB-style port, block_order at byte address 0. It is to be
//   written only while the block is idle, by the user; the block does not
//   enforce that. Zero acts as order 1, above 8 clamps to 8.
// Operation: load and clear act as the request is taken. A read passes the
//   C read register into the output register. An accumulate at order n walks
//   each C entry with one multiply-accumulate unit: a C read, n A/B reads into
//   a multiply and add pipeline, then a drain and write-back.
// in_ready is high only while the sequencer is idle; one request is worked
//   at a time. A waiting result does not hold off input unless a second read
//   arrives, which then holds until the output register frees.
// Reset (rst_n, synchronous) sets order 8, zeroes C and every flag and
//   empties the output register. A and B are undefined until loaded.
module block_matrix_multiply_accumulate (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_req_type,
  input  logic [2:0]                       in_row_index,
  input  logic [2:0]                       in_col_index,
  input  logic signed [15:0]               in_a_value,
  input  logic signed [15:0]               in_b_value,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [47:0]               out_c_value,
  output logic                             out_saturated,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import bmma_pkg::*;

  logic [ORD_W-1:0] order_r;
  logic [IDX_W-1:0] last;
  logic             cfg_hit;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // Register file: block_order is the only register; other words read zero
  // and drop writes.
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORD_W'(MAX_ORDER);
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      order_r <= pwdata[ORD_W-1:0];
    end
  end

  assign prdata = cfg_hit ? {{(32-ORD_W){1'b0}}, order_r} : '0;
  assign last   = act_last(order_r);

  bmma_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .last        (last),
    .status      (status),
    .cmd         (cmd)
  );

  bmma_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .last          (last),
    .in_row        (in_row_index),
    .in_col        (in_col_index),
    .in_a          (in_a_value),
    .in_b          (in_b_value),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_c_value   (out_c_value),
    .out_saturated (out_saturated)
  );

`ifndef SYNTHESIS
  // The sequencer never goes idle with products still in the pipeline.
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !status.pipe_busy)
    else $error("idle with multiply pipeline busy");

  // Store and output commands never collide in one cycle.
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.ab_wr, cmd.c_clr, cmd.c_rd_req, cmd.c_rd_acc, cmd.c_wr,
              cmd.out_load}))
    else $error("conflicting datapath commands");

  // A read transfer always leaves the sequencer busy for the result step.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type == REQ_READ)) |=> !in_ready)
    else $error("read request did not enter the result step");
`endif

endmodule
